### rtl/vpc_pkg.sv
`timescale 1ns / 1ps

package vpc_pkg;

  // Request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_INVAL  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned OUT_SLOT_W  = 6;
  localparam logic [6:0]  LIMIT_RESET = 7'd64;
  localparam logic [31:0] CNT_SAT     = 32'hFFFF_FFFF;

  typedef logic [1:0] req_t;

  // One table entry as held in the tag RAM
  typedef struct packed {
    logic [31:0] space;
    logic [31:0] page;
    logic [63:0] version;
    logic [31:0] count;
  } entry_t;

endpackage

### rtl/vpc_ram.sv
`timescale 1ns / 1ps

module vpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/versioned_page_cache_lfu.sv
`timescale 1ns / 1ps

// Versioned page-tag cache with least-frequently-used eviction. A request is
// taken when start is high and busy is low; every request (lookup, insert,
// invalidate, clear) gives exactly one result word, shown for one cycle with
// out_valid high, and the receiver cannot stall it. Lookup, insert and
// invalidate walk the whole tag RAM once, one slot per cycle through a single
// compare unit behind the RAM's registered read port; clear skips the walk.
// busy stays high until the result is registered, so the next request can
// start in the cycle the result is shown. The capacity limit is written
// through cfg_valid/cfg_ready (always ready); the user must write it only
// while the block is idle, which the block does not enforce. 0 acts as 1,
// values above SLOTS act as SLOTS. Entries need no clearing pass after reset.
module versioned_page_cache_lfu #(
  parameter int SLOTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request
  input  logic                                 start,
  output logic                                 busy,
  input  vpc_pkg::req_t                        in_req_type,
  input  logic [31:0]                          in_space_number,
  input  logic [31:0]                          in_page_number,
  input  logic [63:0]                          in_version_value,
  // result
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [vpc_pkg::OUT_SLOT_W-1:0]       out_slot_index,
  output logic [63:0]                          out_stored_version,
  output logic                                 out_evicted,
  output logic [vpc_pkg::OUT_SLOT_W-1:0]       out_evicted_slot,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vpc_pkg::CFG_W-1:0]            cfg_capacity_limit
);

  import vpc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int LW = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;
  localparam int EW = $bits(entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // control
  logic [1:0]       state_r, state_nxt;
  logic [SW:0]      addr_r, addr_nxt;
  logic             pipe_vld_r, pipe_vld_nxt;
  logic [SW-1:0]    pipe_idx_r, pipe_idx_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SW:0]      used_r, used_nxt;
  logic [CFG_W-1:0] lim_r, lim_nxt;
  logic             need_evict_r, need_evict_nxt;
  logic             match_found_r, match_found_nxt;
  logic             free_found_r, free_found_nxt;
  logic             victim_found_r, victim_found_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  req_t             req_r, req_nxt;
  logic [31:0]      sp_r, sp_nxt;
  logic [31:0]      pg_r, pg_nxt;
  logic [63:0]      ver_r, ver_nxt;
  logic [SW-1:0]    match_idx_r, match_idx_nxt;
  logic [63:0]      match_ver_r, match_ver_nxt;
  logic [31:0]      match_cnt_r, match_cnt_nxt;
  logic [SW-1:0]    free_idx_r, free_idx_nxt;
  logic [SW-1:0]    victim_idx_r, victim_idx_nxt;
  logic [31:0]      best_r, best_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [SW-1:0]    out_slot_r, out_slot_nxt;
  logic [63:0]      out_sver_r, out_sver_nxt;
  logic             out_ev_r, out_ev_nxt;
  logic [SW-1:0]    out_evslot_r, out_evslot_nxt;

  // RAM port
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [SW-1:0]    ram_raddr;
  entry_t           rd_ent;

  // derived
  logic [LW-1:0]    eff_lim;
  logic             issuing;
  logic             ent_vld;
  logic             key_eq;
  logic             ev;
  logic             tgt_found;
  logic             tgt_new;
  logic [SW-1:0]    tgt_idx;
  logic             lk_hit;
  logic [SW+OUT_SLOT_W-1:0] slot_ext;
  logic [SW+OUT_SLOT_W-1:0] evslot_ext;

  vpc_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  // Clamp the limit into 1..SLOTS
  always_comb begin
    eff_lim = LW'(lim_r);
    if (eff_lim == '0) begin
      eff_lim = LW'(1);
    end
    if (eff_lim > LW'(SLOTS)) begin
      eff_lim = LW'(SLOTS);
    end
  end

  assign issuing = (addr_r < (SW + 1)'(SLOTS));
  assign ent_vld = valid_r[pipe_idx_r];
  assign key_eq  = (rd_ent.space == sp_r) && (rd_ent.page == pg_r);

  // Insert: victim first, then surviving match, else lower free/victim slot
  assign ev = (req_r == REQ_INSERT) && need_evict_r && victim_found_r;
  always_comb begin
    tgt_found = 1'b0;
    tgt_new   = 1'b0;
    tgt_idx   = '0;
    if (match_found_r && !(ev && (match_idx_r == victim_idx_r))) begin
      tgt_found = 1'b1;
      tgt_idx   = match_idx_r;
    end else if (free_found_r && (!ev || (free_idx_r < victim_idx_r))) begin
      tgt_found = 1'b1;
      tgt_new   = 1'b1;
      tgt_idx   = free_idx_r;
    end else if (ev) begin
      tgt_found = 1'b1;
      tgt_new   = 1'b1;
      tgt_idx   = victim_idx_r;
    end
  end

  assign lk_hit = match_found_r && ((ver_r == '0) || (match_ver_r >= ver_r));

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    addr_nxt         = addr_r;
    pipe_vld_nxt     = 1'b0;
    pipe_idx_nxt     = pipe_idx_r;
    valid_nxt        = valid_r;
    used_nxt         = used_r;
    lim_nxt          = lim_r;
    need_evict_nxt   = need_evict_r;
    match_found_nxt  = match_found_r;
    free_found_nxt   = free_found_r;
    victim_found_nxt = victim_found_r;
    out_valid_nxt    = 1'b0;
    req_nxt          = req_r;
    sp_nxt           = sp_r;
    pg_nxt           = pg_r;
    ver_nxt          = ver_r;
    match_idx_nxt    = match_idx_r;
    match_ver_nxt    = match_ver_r;
    match_cnt_nxt    = match_cnt_r;
    free_idx_nxt     = free_idx_r;
    victim_idx_nxt   = victim_idx_r;
    best_nxt         = best_r;
    out_hit_nxt      = out_hit_r;
    out_slot_nxt     = out_slot_r;
    out_sver_nxt     = out_sver_r;
    out_ev_nxt       = out_ev_r;
    out_evslot_nxt   = out_evslot_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_raddr        = addr_r[SW-1:0];

    if (cfg_valid) begin
      lim_nxt = cfg_capacity_limit;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt          = in_req_type;
          sp_nxt           = in_space_number;
          pg_nxt           = in_page_number;
          ver_nxt          = in_version_value;
          need_evict_nxt   = (LW'(used_r) >= eff_lim);
          match_found_nxt  = 1'b0;
          free_found_nxt   = 1'b0;
          victim_found_nxt = 1'b0;
          addr_nxt         = '0;
          state_nxt        = (in_req_type == REQ_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, evaluate the previous one
        pipe_vld_nxt = issuing;
        pipe_idx_nxt = addr_r[SW-1:0];
        if (issuing) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (pipe_vld_r) begin
          if (ent_vld && key_eq && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = pipe_idx_r;
            match_ver_nxt   = rd_ent.version;
            match_cnt_nxt   = rd_ent.count;
          end
          if (!ent_vld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pipe_idx_r;
          end
          // smallest count, ties to the lowest slot
          if (ent_vld) begin
            if (!victim_found_r) begin
              victim_found_nxt = 1'b1;
              victim_idx_nxt   = pipe_idx_r;
              best_nxt         = rd_ent.count;
            end else if (rd_ent.count < best_r) begin
              victim_idx_nxt = pipe_idx_r;
              best_nxt       = rd_ent.count;
            end
          end
        end
        if (!issuing && !pipe_vld_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        out_valid_nxt  = 1'b1;
        out_hit_nxt    = 1'b0;
        out_slot_nxt   = '0;
        out_sver_nxt   = '0;
        out_ev_nxt     = 1'b0;
        out_evslot_nxt = '0;
        state_nxt      = ST_IDLE;
        case (req_r)
          REQ_LOOKUP: begin
            if (lk_hit) begin
              out_hit_nxt     = 1'b1;
              out_slot_nxt    = match_idx_r;
              out_sver_nxt    = match_ver_r;
              ram_we          = 1'b1;
              ram_waddr       = match_idx_r;
              ram_wdata.space = sp_r;
              ram_wdata.page  = pg_r;
              ram_wdata.version = match_ver_r;
              ram_wdata.count = (match_cnt_r == CNT_SAT) ? match_cnt_r
                                                         : match_cnt_r + 32'd1;
            end
          end
          REQ_INSERT: begin
            if (ev) begin
              valid_nxt[victim_idx_r] = 1'b0;
              out_ev_nxt     = 1'b1;
              out_evslot_nxt = victim_idx_r;
            end
            if (tgt_found) begin
              valid_nxt[tgt_idx] = 1'b1;
              out_slot_nxt       = tgt_idx;
              ram_we             = 1'b1;
              ram_waddr          = tgt_idx;
              ram_wdata.space    = sp_r;
              ram_wdata.page     = pg_r;
              ram_wdata.version  = ver_r;
              ram_wdata.count    = 32'd1;
            end
            used_nxt = used_r - (SW + 1)'(ev) + (SW + 1)'(tgt_new);
          end
          REQ_INVAL: begin
            if (match_found_r) begin
              valid_nxt[match_idx_r] = 1'b0;
              used_nxt = used_r - 1'b1;
            end
          end
          default: begin
            valid_nxt = '0;
            used_nxt  = '0;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      addr_r         <= '0;
      pipe_vld_r     <= 1'b0;
      pipe_idx_r     <= '0;
      valid_r        <= '0;
      used_r         <= '0;
      lim_r          <= LIMIT_RESET;
      need_evict_r   <= 1'b0;
      match_found_r  <= 1'b0;
      free_found_r   <= 1'b0;
      victim_found_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      addr_r         <= addr_nxt;
      pipe_vld_r     <= pipe_vld_nxt;
      pipe_idx_r     <= pipe_idx_nxt;
      valid_r        <= valid_nxt;
      used_r         <= used_nxt;
      lim_r          <= lim_nxt;
      need_evict_r   <= need_evict_nxt;
      match_found_r  <= match_found_nxt;
      free_found_r   <= free_found_nxt;
      victim_found_r <= victim_found_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    sp_r         <= sp_nxt;
    pg_r         <= pg_nxt;
    ver_r        <= ver_nxt;
    match_idx_r  <= match_idx_nxt;
    match_ver_r  <= match_ver_nxt;
    match_cnt_r  <= match_cnt_nxt;
    free_idx_r   <= free_idx_nxt;
    victim_idx_r <= victim_idx_nxt;
    best_r       <= best_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sver_r   <= out_sver_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evslot_r <= out_evslot_nxt;
  end

  // Result word, slot numbers carried in their low bits
  assign slot_ext   = (SW + OUT_SLOT_W)'(out_slot_r);
  assign evslot_ext = (SW + OUT_SLOT_W)'(out_evslot_r);

  assign busy               = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_slot_index     = slot_ext[OUT_SLOT_W-1:0];
  assign out_stored_version = out_sver_r;
  assign out_evicted        = out_ev_r;
  assign out_evicted_slot   = evslot_ext[OUT_SLOT_W-1:0];

endmodule
